FILE: hdl/blgs_pkg.sv
// Shared types, constants and period/offset functions for the bond stiffness block.
package blgs_pkg;

	localparam int IdxW = 16;
	localparam int BqW = 19;

	localparam logic signed [BqW-1:0] Bq11 = -19'sd15991;
	localparam logic signed [BqW-1:0] Bq12 = 19'sd23069;
	localparam logic signed [BqW-1:0] Bq13 = 19'sd43254;
	localparam logic signed [BqW-1:0] Bq22 = 19'sd71107;
	localparam logic signed [BqW-1:0] Bq23 = 19'sd99746;
	localparam logic signed [BqW-1:0] BqXx = 19'sd135528;

	localparam logic [32:0] KNumHi = 33'd113639 << 16;

	typedef enum logic [1:0] {
		PER_ONE,
		PER_TWO,
		PER_THREE,
		PER_OTHER
	} period_t;

	typedef struct packed {
		logic                  load;
		logic [IdxW-1:0]       idx_a;
		logic [IdxW-1:0]       idx_b;
		logic                  ok_a;
		logic                  ok_b;
		logic signed [BqW-1:0] bq;
		logic signed [31:0]    x;
		logic signed [31:0]    y;
		logic signed [31:0]    z;
	} req_t;

	function automatic period_t period_of(input logic [6:0] num);
		period_t p;
		if (num >= 7'd1 && num <= 7'd2) p = PER_ONE;
		else if (num >= 7'd3 && num <= 7'd10) p = PER_TWO;
		else if (num >= 7'd11 && num <= 7'd18) p = PER_THREE;
		else p = PER_OTHER;
		return p;
	endfunction

	function automatic logic signed [BqW-1:0] pick_b(input period_t pa, input period_t pb);
		logic signed [BqW-1:0] b;
		if (pa == PER_ONE && pb == PER_ONE) b = Bq11;
		else if ((pa == PER_ONE && pb == PER_TWO) || (pa == PER_TWO && pb == PER_ONE)) b = Bq12;
		else if ((pa == PER_ONE && pb == PER_THREE) || (pa == PER_THREE && pb == PER_ONE))
			b = Bq13;
		else if (pa == PER_TWO && pb == PER_TWO) b = Bq22;
		else if ((pa == PER_TWO && pb == PER_THREE) || (pa == PER_THREE && pb == PER_TWO))
			b = Bq23;
		else b = BqXx;
		return b;
	endfunction

endpackage

FILE: hdl/bond_length_gradient_stiffness.sv
// Top level of the bond length, gradient and stiffness guess block.
//
// Request channel (req_valid / req_stall): mode 0 loads x, y, z of atom_first
// into the coordinate store; mode 1 queries the bond atom_first - atom_second
// with the atomic numbers element_first / element_second.
// Response channel (rsp_valid / rsp_stall): one response per query, none per
// load, in request order: bond_length, unit vector, stiffness_guess and flags.
// Throughput: one request per cycle while rsp_stall does not hold the
// pipeline, set by the fully pipelined square root (33 stages) and
// restoring dividers (36 and 33 stages). A load is written into the
// coordinate store when it leaves the request queue.
// A four-entry request queue separates the front end from the pipeline.
// While rsp_valid and rsp_stall are high the pipeline holds, the queue fills
// and req_stall rises once it is full; no request or response is dropped.
// Reset clears the queue and pipeline valid state; the coordinate store is not
// cleared, and an atom must be loaded before it is queried.
module bond_length_gradient_stiffness #(
	parameter int MAX_ATOMS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                mode,
	input  logic [9:0]          atom_first,
	input  logic [9:0]          atom_second,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic signed [31:0]  coord_z,
	input  logic [6:0]          element_first,
	input  logic [6:0]          element_second,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [31:0]         bond_length,
	output logic signed [17:0]  unit_x,
	output logic signed [17:0]  unit_y,
	output logic signed [17:0]  unit_z,
	output logic signed [31:0]  stiffness_guess,
	output logic                zero_length,
	output logic                saturated
);

	logic q_valid;
	logic q_pop;
	blgs_pkg::req_t q_item;

	blgs_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.mode           (mode),
		.atom_first     (atom_first),
		.atom_second    (atom_second),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.element_first  (element_first),
		.element_second (element_second),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	blgs_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.bond_length     (bond_length),
		.unit_x          (unit_x),
		.unit_y          (unit_y),
		.unit_z          (unit_z),
		.stiffness_guess (stiffness_guess),
		.zero_length     (zero_length),
		.saturated       (saturated)
	);

endmodule

FILE: hdl/blgs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module blgs_ram #(
	parameter int Width = 96,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr_a,
	input  logic [$clog2(Depth)-1:0] raddr_b,
	output logic [Width-1:0]         rdata_a,
	output logic [Width-1:0]         rdata_b
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

FILE: hdl/blgs_front.sv
// Front end: accept requests, classify them and queue them for the back end.
module blgs_front #(
	parameter int MAX_ATOMS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                mode,
	input  logic [9:0]          atom_first,
	input  logic [9:0]          atom_second,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic signed [31:0]  coord_z,
	input  logic [6:0]          element_first,
	input  logic [6:0]          element_second,
	output logic                q_valid,
	output blgs_pkg::req_t      q_item,
	input  logic                q_pop
);

	localparam int Depth = 4;

	blgs_pkg::req_t mem_q [Depth];
	blgs_pkg::req_t item;
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push;

	assign req_stall = cnt_q == 3'(Depth);
	assign push = req_valid & ~req_stall;
	assign q_valid = cnt_q != 3'd0;
	assign q_item = mem_q[rp_q];

	always_comb begin
		item.load  = ~mode;
		item.idx_a = blgs_pkg::IdxW'(atom_first);
		item.idx_b = blgs_pkg::IdxW'(atom_second);
		item.ok_a  = 17'(atom_first) < 17'(MAX_ATOMS);
		item.ok_b  = 17'(atom_second) < 17'(MAX_ATOMS);
		item.bq    = blgs_pkg::pick_b(blgs_pkg::period_of(element_first),
			blgs_pkg::period_of(element_second));
		item.x     = coord_x;
		item.y     = coord_y;
		item.z     = coord_z;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (q_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end

endmodule

FILE: hdl/blgs_sqrt.sv
// Pipelined floor square root of a 66-bit value, one result bit per stage.
module blgs_sqrt #(
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [65:0]   val,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [32:0]   root,
	output logic [SW-1:0] side_out
);

	localparam int N = 33;

	logic [32:0]   root_s [N];
	logic [36:0]   rem_s  [N];
	logic [65:0]   val_s  [N];
	logic          vld_s  [N];
	logic [SW-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [32:0]   root_i;
		logic [36:0]   rem_i;
		logic [65:0]   val_i;
		logic          vld_i;
		logic [SW-1:0] side_i;
		logic [36:0]   rem_n;
		logic [36:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign root_i = '0;
			assign rem_i  = '0;
			assign val_i  = val;
			assign vld_i  = in_vld;
			assign side_i = side_in;
		end else begin : g_next
			assign root_i = root_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign val_i  = val_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign rem_n = {rem_i[34:0], val_i[65:64]};
		assign trial = {2'b00, root_i, 2'b01};
		assign ge = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_n - trial : rem_n;
				root_s[k] <= {root_i[31:0], ge};
				val_s[k]  <= {val_i[63:0], 2'b00};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld = vld_s[N-1];
	assign root = root_s[N-1];
	assign side_out = side_s[N-1];

endmodule

FILE: hdl/blgs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module blgs_div #(
	parameter int QW = 33,
	parameter int DW = 33,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] rem0,
	input  logic [QW-1:0] lo,
	input  logic [DW-1:0] dvs,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] lo_s   [QW];
	logic [DW-1:0] dvs_s  [QW];
	logic [QW-1:0] q_s    [QW];
	logic          vld_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [QW-1:0] lo_i;
		logic [DW-1:0] dvs_i;
		logic [QW-1:0] q_i;
		logic          vld_i;
		logic [SW-1:0] side_i;
		logic [DW:0]   r2;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i  = rem0;
			assign lo_i   = lo;
			assign dvs_i  = dvs;
			assign q_i    = '0;
			assign vld_i  = in_vld;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign lo_i   = lo_s[k-1];
			assign dvs_i  = dvs_s[k-1];
			assign q_i    = q_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign r2 = {rem_i, lo_i[QW-1]};
		assign diff = r2 - {1'b0, dvs_i};
		assign ge = r2 >= {1'b0, dvs_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
				lo_s[k]   <= {lo_i[QW-2:0], 1'b0};
				dvs_s[k]  <= dvs_i;
				q_s[k]    <= {q_i[QW-2:0], ge};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign quo = q_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

FILE: hdl/blgs_back.sv
// Back end: coordinate store, distance, square root, unit vector and stiffness pipeline.
module blgs_back #(
	parameter int MAX_ATOMS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  blgs_pkg::req_t      q_item,
	output logic                q_pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [31:0]         bond_length,
	output logic signed [17:0]  unit_x,
	output logic signed [17:0]  unit_y,
	output logic signed [17:0]  unit_z,
	output logic signed [31:0]  stiffness_guess,
	output logic                zero_length,
	output logic                saturated
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam int BqW = blgs_pkg::BqW;
	localparam int SqSw = 3 * 33 + BqW;

	typedef struct packed {
		logic        neg;
		logic        a_zero;
		logic        a_small;
		logic        a_big;
		logic [31:0] blen;
		logic        sat_len;
		logic        zero;
	} tail_t;

	logic en;
	logic ram_re;
	logic ram_we;
	logic [95:0] rdata_a, rdata_b;

	assign en = ~rsp_valid | ~rsp_stall;
	assign q_pop = q_valid & en;
	assign ram_we = q_pop & q_item.load & q_item.ok_a;
	assign ram_re = q_pop & ~q_item.load;

	blgs_ram #(.Width(96), .Depth(MAX_ATOMS)) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (q_item.idx_a[AW-1:0]),
		.wdata   ({q_item.x, q_item.y, q_item.z}),
		.re      (ram_re),
		.raddr_a (q_item.idx_a[AW-1:0]),
		.raddr_b (q_item.idx_b[AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	logic vld_s1, oka_s1, okb_s1;
	logic signed [BqW-1:0] bq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= q_valid & ~q_item.load;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oka_s1 <= q_item.ok_a;
			okb_s1 <= q_item.ok_b;
			bq_s1  <= q_item.bq;
		end
	end

	logic signed [32:0] pa_c [3];
	logic signed [32:0] pb_c [3];
	logic signed [32:0] d_c [3];
	logic [32:0] mag_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa_c[k] = oka_s1 ? 33'(signed'(rdata_a[95-32*k -: 32])) : '0;
			pb_c[k] = okb_s1 ? 33'(signed'(rdata_b[95-32*k -: 32])) : '0;
			d_c[k] = pa_c[k] - pb_c[k];
			mag_c[k] = d_c[k][32] ? 33'(-d_c[k]) : 33'(d_c[k]);
		end
	end

	logic vld_s2, vld_s3, vld_s4;
	logic signed [32:0] d_s2 [3];
	logic signed [32:0] d_s3 [3];
	logic signed [32:0] d_s4 [3];
	logic [32:0] mag_s2 [3];
	logic [65:0] sq_s3 [3];
	logic [65:0] sum_s4;
	logic signed [BqW-1:0] bq_s2, bq_s3, bq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s2[k]   <= d_c[k];
				mag_s2[k] <= mag_c[k];
				d_s3[k]   <= d_s2[k];
				sq_s3[k]  <= 66'(mag_s2[k]) * 66'(mag_s2[k]);
				d_s4[k]   <= d_s3[k];
			end
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			bq_s2 <= bq_s1;
			bq_s3 <= bq_s2;
			bq_s4 <= bq_s3;
		end
	end

	logic vld_r;
	logic [32:0] root_r;
	logic [SqSw-1:0] side_r;

	blgs_sqrt #(.SW(SqSw)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.val      (sum_s4),
		.side_in  ({d_s4[0], d_s4[1], d_s4[2], bq_s4}),
		.out_vld  (vld_r),
		.root     (root_r),
		.side_out (side_r)
	);

	logic signed [32:0] dr_c [3];
	logic [32:0] mr_c [3];
	logic signed [BqW-1:0] bq_r;
	logic signed [34:0] t_c;
	logic [34:0] a_c;
	tail_t tail_c;

	always_comb begin
		dr_c[0] = signed'(side_r[SqSw-1 -: 33]);
		dr_c[1] = signed'(side_r[SqSw-34 -: 33]);
		dr_c[2] = signed'(side_r[SqSw-67 -: 33]);
		bq_r = signed'(side_r[BqW-1:0]);
		for (int k = 0; k < 3; k++) begin
			mr_c[k] = dr_c[k][32] ? 33'(-dr_c[k]) : 33'(dr_c[k]);
		end
		t_c = signed'({2'b00, root_r}) - 35'(bq_r);
		a_c = t_c[34] ? 35'(-t_c) : 35'(t_c);
		tail_c.neg     = t_c[34];
		tail_c.a_zero  = a_c == 35'd0;
		tail_c.a_small = a_c < 35'd16;
		tail_c.a_big   = a_c[34:22] != 13'd0;
		tail_c.blen    = root_r[32] ? 32'hFFFF_FFFF : root_r[31:0];
		tail_c.sat_len = root_r[32];
		tail_c.zero    = root_r == 33'd0;
	end

	logic vld_s5, vld_s6, vld_s7, vld_s8;
	logic [48:0] num_s5 [3];
	logic usgn_s5 [3];
	logic [32:0] root_s5;
	logic [21:0] a_s5, a_s6;
	logic [43:0] a2_s6;
	logic [65:0] a3_s7, a3_s8;
	logic ovf_s8;
	tail_t tail_s5, tail_s6, tail_s7, tail_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_r;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s5[k]  <= {mr_c[k], 16'd0} + 49'(root_r >> 1);
				usgn_s5[k] <= dr_c[k][32];
			end
			root_s5 <= root_r;
			a_s5    <= a_c[21:0];
			tail_s5 <= tail_c;
			a_s6    <= a_s5;
			a2_s6   <= 44'(a_s5) * 44'(a_s5);
			tail_s6 <= tail_s5;
			a3_s7   <= 66'(a2_s6) * 66'(a_s6);
			tail_s7 <= tail_s6;
			a3_s8   <= a3_s7;
			ovf_s8  <= {33'd0, blgs_pkg::KNumHi} >= a3_s7;
			tail_s8 <= tail_s7;
		end
	end

	logic [35:0] uquo [3];
	logic usgn_o [3];
	logic uvld [3];

	for (genvar k = 0; k < 3; k++) begin : g_unit
		blgs_div #(.QW(36), .DW(33), .SW(1)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_s5),
			.rem0     (33'(num_s5[k][48:36])),
			.lo       (num_s5[k][35:0]),
			.dvs      (root_s5),
			.side_in  (usgn_s5[k]),
			.out_vld  (uvld[k]),
			.quo      (uquo[k]),
			.side_out (usgn_o[k])
		);
	end

	logic svld;
	logic [32:0] squo;
	logic sovf;
	tail_t stail;

	blgs_div #(.QW(33), .DW(66), .SW($bits(tail_t) + 1)) u_stiff_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.rem0     (66'(blgs_pkg::KNumHi)),
		.lo       (33'd0),
		.dvs      (a3_s8),
		.side_in  ({ovf_s8, tail_s8}),
		.out_vld  (svld),
		.quo      (squo),
		.side_out ({sovf, stail})
	);

	logic [33:0] smag_c;
	logic signed [31:0] stiff_c;
	logic ssat_c;
	logic [17:0] uq_c [3];
	logic [17:0] uo_c [3];

	always_comb begin
		smag_c = (34'(squo) + 34'd1) >> 1;
		ssat_c = 1'b0;
		stiff_c = '0;
		if (stail.a_zero) begin
			stiff_c = 32'sh7FFF_FFFF;
			ssat_c = 1'b1;
		end else if (stail.a_small) begin
			stiff_c = stail.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			ssat_c = 1'b1;
		end else if (stail.a_big) begin
			stiff_c = '0;
		end else if (!stail.neg) begin
			if (sovf || smag_c > 34'h0_7FFF_FFFF) begin
				stiff_c = 32'sh7FFF_FFFF;
				ssat_c = 1'b1;
			end else begin
				stiff_c = signed'(smag_c[31:0]);
			end
		end else begin
			if (sovf || smag_c > 34'h0_8000_0000) begin
				stiff_c = 32'sh8000_0000;
				ssat_c = 1'b1;
			end else begin
				stiff_c = signed'(32'(-smag_c));
			end
		end
		for (int k = 0; k < 3; k++) begin
			uq_c[k] = uquo[k][17:0];
			uo_c[k] = stail.zero ? 18'd0 : (usgn_o[k] ? -uq_c[k] : uq_c[k]);
		end
	end

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (en) valid_q <= svld & uvld[0] & uvld[1] & uvld[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bond_length     <= stail.blen;
			unit_x          <= signed'(uo_c[0]);
			unit_y          <= signed'(uo_c[1]);
			unit_z          <= signed'(uo_c[2]);
			stiffness_guess <= stiff_c;
			zero_length     <= stail.zero;
			saturated       <= stail.sat_len | ssat_c;
		end
	end

	assign rsp_valid = valid_q;

endmodule

FILE: verif/tb_bond_length_gradient_stiffness.sv
// Testbench for bond_length_gradient_stiffness: random and directed loads and bond queries.
`timescale 1ns / 100ps

module tb_bond_length_gradient_stiffness;

	typedef struct packed {
		logic [31:0]        length;
		logic signed [17:0] ux;
		logic signed [17:0] uy;
		logic signed [17:0] uz;
		logic signed [31:0] stiff;
		logic               zero;
		logic               sat;
	} bond_result_t;

	localparam int IdleLimit = 5000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               mode = 1'b0;
	logic [9:0]         atom_first = '0;
	logic [9:0]         atom_second = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic signed [31:0] coord_z = '0;
	logic [6:0]         element_first = '0;
	logic [6:0]         element_second = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [31:0]        bond_length;
	logic signed [17:0] unit_x;
	logic signed [17:0] unit_y;
	logic signed [17:0] unit_z;
	logic signed [31:0] stiffness_guess;
	logic               zero_length;
	logic               saturated;

	bond_result_t       bonds_due[$];
	logic signed [31:0] atom_pos[1024][3];
	bit                 atom_loaded[1024];
	int                 loaded_list[$];
	int                 fail_count = 0;
	int                 quiet_cycles = 0;
	bit                 idling_on = 1'b1;
	int                 hold_request = 0;

	bond_length_gradient_stiffness dut (.*);

	always #5 clk = ~clk;

	function automatic blgs_pkg::period_t row_of_element(input logic [6:0] num);
		if (num >= 1 && num <= 2) return blgs_pkg::PER_ONE;
		if (num >= 3 && num <= 10) return blgs_pkg::PER_TWO;
		if (num >= 11 && num <= 18) return blgs_pkg::PER_THREE;
		return blgs_pkg::PER_OTHER;
	endfunction

	function automatic longint bond_offset(input blgs_pkg::period_t pa,
			input blgs_pkg::period_t pb);
		blgs_pkg::period_t lo, hi;
		lo = (pa < pb) ? pa : pb;
		hi = (pa < pb) ? pb : pa;
		if (lo == blgs_pkg::PER_ONE && hi == blgs_pkg::PER_ONE) return -15991;
		if (lo == blgs_pkg::PER_ONE && hi == blgs_pkg::PER_TWO) return 23069;
		if (lo == blgs_pkg::PER_ONE && hi == blgs_pkg::PER_THREE) return 43254;
		if (lo == blgs_pkg::PER_TWO && hi == blgs_pkg::PER_TWO) return 71107;
		if (lo == blgs_pkg::PER_TWO && hi == blgs_pkg::PER_THREE) return 99746;
		return 135528;
	endfunction

	function automatic logic [33:0] floor_root(input logic [65:0] v);
		logic [67:0] rem, trial;
		logic [33:0] root;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'((v >> (2 * i)) & 66'd3);
			trial = ({34'd0, root} << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 34'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [17:0] unit_part(input longint d, input longint unsigned r);
		longint unsigned mag, q;
		if (r == 0) return '0;
		mag = (d < 0) ? -d : d;
		q = (mag * 65536 + r / 2) / r;
		return 18'((d < 0) ? -q : q);
	endfunction

	function automatic logic signed [31:0] stretch_constant(input longint t, inout logic sat);
		longint unsigned a, hi, qh, rh, q1, q3, mag;
		a = (t < 0) ? -t : t;
		if (a == 0) begin
			sat = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (a < 16) begin
			sat = 1'b1;
			return (t < 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
		if (a >= (64'd1 << 22)) return '0;
		hi = 64'd113639 << 17;
		qh = hi / a;
		rh = hi % a;
		q1 = (qh << 32) + ((rh << 32) / a);
		q3 = (q1 / a) / a;
		mag = (q3 + 1) >> 1;
		if (t > 0) begin
			if (mag > 64'd2147483647) begin
				sat = 1'b1;
				return 32'sh7FFFFFFF;
			end
			return 32'(mag);
		end
		if (mag > 64'd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return 32'(-mag);
	endfunction

	function automatic bond_result_t predict_bond(input int ia, input int ib,
			input logic [6:0] ea, input logic [6:0] eb);
		bond_result_t res;
		longint d[3];
		logic [65:0] sum;
		logic [33:0] root;
		logic sat;
		sum = '0;
		sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d[k] = longint'(atom_pos[ia][k]) - longint'(atom_pos[ib][k]);
			sum += 66'(d[k] * d[k]) & 66'hFFFF_FFFF_FFFF_FFFF;
			if (d[k] * d[k] == 0 && (d[k] == 64'sh1_0000_0000 || d[k] == -64'sh1_0000_0000))
				sum += 66'h1_0000_0000_0000_0000;
		end
		root = floor_root(sum);
		res.length = (root > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
		if (root > 34'hFFFF_FFFF) sat = 1'b1;
		res.ux = unit_part(d[0], root);
		res.uy = unit_part(d[1], root);
		res.uz = unit_part(d[2], root);
		res.stiff = stretch_constant(longint'(root) -
			bond_offset(row_of_element(ea), row_of_element(eb)), sat);
		res.zero = (root == 0);
		res.sat = sat;
		return res;
	endfunction

	task automatic send_request(input logic m, input int a, input int b,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic [6:0] ea, input logic [6:0] eb);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		atom_first <= 10'(a);
		atom_second <= 10'(b);
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		element_first <= ea;
		element_second <= eb;
		do @(posedge clk); while (req_stall);
		if (m) begin
			bonds_due.push_back(predict_bond(a, b, ea, eb));
		end else begin
			atom_pos[a][0] = x;
			atom_pos[a][1] = y;
			atom_pos[a][2] = z;
			if (!atom_loaded[a]) loaded_list.push_back(a);
			atom_loaded[a] = 1'b1;
		end
	endtask

	task automatic load_atom(input int a, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		send_request(1'b0, a, $urandom_range(0, 1023), x, y, z,
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
	endtask

	task automatic query_bond(input int a, input int b, input logic [6:0] ea,
			input logic [6:0] eb);
		send_request(1'b1, a, b, $urandom, $urandom, $urandom, ea, eb);
	endtask

	function automatic logic signed [31:0] random_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
			default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
		endcase
	endfunction

	function automatic logic [6:0] random_element();
		return 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 118) :
			$urandom_range(0, 20));
	endfunction

	task automatic test_directed();
		logic [6:0] elems[8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd10, 7'd11, 7'd18, 7'd118};
		load_atom(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		load_atom(1023, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		load_atom(1, 0, 0, 0);
		load_atom(2, 135528, 0, 0);
		load_atom(3, 0, 71107 + 5, 0);
		load_atom(4, -3000000, 2000000, -5000000);
		query_bond(0, 1023, 7'd0, 7'd0);
		query_bond(1, 1, 7'd1, 7'd1);
		query_bond(2, 1, 7'd0, 7'd118);
		query_bond(1, 3, 7'd3, 7'd10);
		query_bond(4, 1, 7'd11, 7'd18);
		for (int i = 0; i < 8; i++)
			query_bond(2 + i % 2, 1, elems[i], elems[7 - i]);
	endtask

	task automatic test_random(input int count);
		int a, b;
		for (int n = 0; n < count; n++) begin
			if (loaded_list.size() < 2 || $urandom_range(0, 9) < 3) begin
				a = (loaded_list.size() > 0 && $urandom_range(0, 2) == 0) ?
					loaded_list[$urandom_range(0, loaded_list.size() - 1)] :
					$urandom_range(0, 1023);
				load_atom(a, random_coord(), random_coord(), random_coord());
			end else begin
				a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				query_bond(a, b, random_element(), random_element());
			end
		end
	endtask

	task automatic test_backpressure();
		hold_request = 400;
		test_random(40);
	endtask

	task automatic test_drain();
		req_valid <= 1'b0;
		while (bonds_due.size() > 0) @(posedge clk);
		test_random(30);
	endtask

	task automatic test_full_rate();
		idling_on = 1'b0;
		test_random(100);
	endtask

	always @(posedge clk) begin
		int burst;
		if (hold_request > 0) begin
			rsp_stall <= 1'b1;
			hold_request <= hold_request - 1;
		end else if (burst > 0) begin
			burst--;
			rsp_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			burst = $urandom_range(0, 17);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		bond_result_t want;
		if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (bonds_due.size() == 0) begin
				$error("unexpected bond result");
				fail_count++;
			end else begin
				want = bonds_due.pop_front();
				if (bond_length !== want.length) begin
					$error("bond_length exp %h got %h", want.length, bond_length);
					fail_count++;
				end
				if (unit_x !== want.ux) begin
					$error("unit_x exp %h got %h", want.ux, unit_x);
					fail_count++;
				end
				if (unit_y !== want.uy) begin
					$error("unit_y exp %h got %h", want.uy, unit_y);
					fail_count++;
				end
				if (unit_z !== want.uz) begin
					$error("unit_z exp %h got %h", want.uz, unit_z);
					fail_count++;
				end
				if (stiffness_guess !== want.stiff) begin
					$error("stiffness_guess exp %h got %h", want.stiff, stiffness_guess);
					fail_count++;
				end
				if (zero_length !== want.zero) begin
					$error("zero_length exp %b got %b", want.zero, zero_length);
					fail_count++;
				end
				if (saturated !== want.sat) begin
					$error("saturated exp %b got %b", want.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_backpressure();
		test_drain();
		test_random(150);
		test_full_rate();
		req_valid <= 1'b0;
		while (bonds_due.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: bond_length_gradient_stiffness.f
hdl/blgs_pkg.sv
hdl/blgs_ram.sv
hdl/blgs_front.sv
hdl/blgs_sqrt.sv
hdl/blgs_div.sv
hdl/blgs_back.sv
hdl/bond_length_gradient_stiffness.sv
verif/tb_bond_length_gradient_stiffness.sv
